@@ src/sata_pkg.sv @@
// ----------------------------------------------------------------------------
// sata_pkg
// Shared types, widths and constants of the seen-address table with aging.
// ----------------------------------------------------------------------------
package sata_pkg;

    localparam int TABLE_ENTRIES = 16;

    localparam int ADDR_W  = 48;
    localparam int TIME_W  = 32;
    localparam int UUID_W  = 16;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int OUT_CNT_W = 5;

    localparam logic [TIME_W-1:0] FORGET_RESET = 32'd1200000;
    localparam logic [UUID_W-1:0] UUID_RESET   = 16'hfd6f;

    localparam logic [OUT_CNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [OUT_CNT_W-1:0] LIVE_MAX  =
        (TABLE_ENTRIES > 31) ? 5'd31 : OUT_CNT_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        VERDICT_IGNORED = 3'd0,
        VERDICT_NEW     = 3'd1,
        VERDICT_AGAIN   = 3'd2,
        VERDICT_FULL    = 3'd3,
        VERDICT_SWEEP   = 3'd4
    } verdict_t;

    // what a token asks of each cell it passes
    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_LOOK  = 2'd1,
        OP_SWEEP = 2'd2
    } op_t;

    typedef enum logic {
        REG_FORGET = 1'b0,
        REG_UUID   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic              active;
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
        logic              hit;
        logic              free_found;
        logic [CNT_W-1:0]  removed;
        logic [CNT_W-1:0]  live;
    } token_t;

    function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        logic [CNT_W+OUT_CNT_W-1:0] wide;
        wide = (CNT_W + OUT_CNT_W)'(v);
        if (wide > (CNT_W + OUT_CNT_W)'(COUNT_MAX)) begin
            return COUNT_MAX;
        end
        return wide[OUT_CNT_W-1:0];
    endfunction

endpackage

@@ src/sata_cell.sv @@
// ----------------------------------------------------------------------------
// sata_cell
// One table slot: holds address, last-seen time and valid bit, and updates a
// passing token with its own contribution before handing it on.
// ----------------------------------------------------------------------------
module sata_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sata_pkg::token_t              tok_i,
    input  logic [sata_pkg::TIME_W-1:0]   forget_ms,
    input  logic                          commit_i,
    output sata_pkg::token_t              tok_o
);

    logic                          valid_reg, valid_next;
    logic                          cand_reg, cand_next;
    logic [sata_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [sata_pkg::TIME_W-1:0]   last_reg, last_next;
    sata_pkg::token_t              tok_reg, tok_next;
    logic [sata_pkg::TIME_W-1:0]   expiry;
    logic                          expired;

    // wraps modulo 2^32 by width
    assign expiry  = last_reg + forget_ms;
    assign expired = expiry < tok_i.now;

    always_comb begin
        tok_next   = tok_i;
        valid_next = valid_reg;
        cand_next  = cand_reg;
        addr_next  = addr_reg;
        last_next  = last_reg;

        // end of a report pass: the claimed free slot becomes live if asked
        if (commit_i) begin
            cand_next = 1'b0;
            if (cand_reg) begin
                valid_next = 1'b1;
            end
        end

        if (tok_i.active) begin
            case (tok_i.op)
                sata_pkg::OP_SWEEP: begin
                    if (valid_reg && expired) begin
                        valid_next       = 1'b0;
                        tok_next.removed = tok_i.removed + sata_pkg::CNT_W'(1);
                    end else if (valid_reg) begin
                        tok_next.live = tok_i.live + sata_pkg::CNT_W'(1);
                    end
                end
                sata_pkg::OP_LOOK: begin
                    if (valid_reg) begin
                        tok_next.live = tok_i.live + sata_pkg::CNT_W'(1);
                        if (addr_reg == tok_i.addr) begin
                            last_next    = tok_i.now;
                            tok_next.hit = 1'b1;
                        end
                    end else if (!tok_i.free_found) begin
                        // slot is free, so its payload may be written now
                        cand_next           = 1'b1;
                        tok_next.free_found = 1'b1;
                        addr_next           = tok_i.addr;
                        last_next           = tok_i.now;
                    end else begin
                        // a lower free slot took this pass, drop any older claim
                        cand_next = 1'b0;
                    end
                end
                sata_pkg::OP_PASS: begin
                    if (valid_reg) begin
                        tok_next.live = tok_i.live + sata_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    tok_next = tok_i;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        last_reg <= last_next;
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            cand_reg       <= 1'b0;
            tok_reg.active <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

@@ src/seen_address_table_with_aging_top.sv @@
// ----------------------------------------------------------------------------
// seen_address_table_with_aging_top
// Table of device addresses with last-seen times, learning from reports and
// aging entries out on sweep requests.
// ----------------------------------------------------------------------------
// Each beat is handled by one token that walks a row of TABLE_ENTRIES slot
// cells, one cell per cycle, from the input token register to the output
// register, and the block takes one item at a time; the next input beat is
// taken as soon as the result has moved into the output register. A report
// that is new goes into the lowest free slot.

module seen_address_table_with_aging_top (
    input  logic          aclk,
    input  logic          aresetn,
    // configuration write port
    input  logic          cfg_wr_en,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_wdata,
    // input beats
    input  logic          s_tvalid,
    output logic          s_tready,
    // device_address[47:0], uuid_present[48], service_uuid[64:49], now_ms[96:65]
    input  logic [103:0]  s_tdata,
    // req_type[0]
    input  logic          s_tuser,
    // result beats
    output logic          m_tvalid,
    input  logic          m_tready,
    // verdict[2:0], removed_count[7:3], live_count[12:8]
    output logic [15:0]   m_tdata
);

    localparam int N = sata_pkg::TABLE_ENTRIES;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    state_t                             state_reg, state_next;
    logic [sata_pkg::TIME_W-1:0]        forget_reg;
    logic [sata_pkg::UUID_W-1:0]        uuid_reg;
    sata_pkg::token_t                   tok0_reg, tok0_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    sata_pkg::verdict_t                 out_verdict_reg, out_verdict_next;
    logic [sata_pkg::OUT_CNT_W-1:0]     out_removed_reg, out_removed_next;
    logic [sata_pkg::OUT_CNT_W-1:0]     out_live_reg, out_live_next;
    sata_pkg::verdict_t                 pend_verdict_reg, pend_verdict_next;
    logic [sata_pkg::OUT_CNT_W-1:0]     pend_removed_reg, pend_removed_next;
    logic [sata_pkg::OUT_CNT_W-1:0]     pend_live_reg, pend_live_next;

    sata_pkg::token_t                   tok [N+1];
    sata_pkg::token_t                   tok_end;
    logic                               commit;
    sata_pkg::verdict_t                 exit_verdict;
    logic [sata_pkg::CNT_W-1:0]         exit_live;
    logic                               out_free;

    logic [sata_pkg::ADDR_W-1:0]        in_addr;
    logic                               in_present;
    logic [sata_pkg::UUID_W-1:0]        in_uuid;
    logic [sata_pkg::TIME_W-1:0]        in_now;
    sata_pkg::op_t                      in_op;

    assign in_addr    = s_tdata[47:0];
    assign in_present = s_tdata[48];
    assign in_uuid    = s_tdata[64:49];
    assign in_now     = s_tdata[96:65];

    always_comb begin
        if (s_tuser) begin
            in_op = sata_pkg::OP_SWEEP;
        end else if (in_present && (in_uuid == uuid_reg)) begin
            in_op = sata_pkg::OP_LOOK;
        end else begin
            in_op = sata_pkg::OP_PASS;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forget_reg <= sata_pkg::FORGET_RESET;
            uuid_reg   <= sata_pkg::UUID_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sata_pkg::REG_FORGET: forget_reg <= cfg_wdata;
                sata_pkg::REG_UUID:   uuid_reg   <= cfg_wdata[sata_pkg::UUID_W-1:0];
                default:              forget_reg <= forget_reg;
            endcase
        end
    end

    // row of slot cells
    assign tok[0] = tok0_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        sata_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .tok_i     (tok[i]),
            .forget_ms (forget_reg),
            .commit_i  (commit),
            .tok_o     (tok[i+1])
        );
    end

    assign tok_end = tok[N];

    // result of the token leaving the last cell
    always_comb begin
        commit    = 1'b0;
        exit_live = tok_end.live;
        case (tok_end.op)
            sata_pkg::OP_SWEEP: exit_verdict = sata_pkg::VERDICT_SWEEP;
            sata_pkg::OP_LOOK: begin
                if (tok_end.hit) begin
                    exit_verdict = sata_pkg::VERDICT_AGAIN;
                end else if (tok_end.free_found) begin
                    exit_verdict = sata_pkg::VERDICT_NEW;
                    commit       = tok_end.active;
                    exit_live    = tok_end.live + sata_pkg::CNT_W'(1);
                end else begin
                    exit_verdict = sata_pkg::VERDICT_FULL;
                end
            end
            default: exit_verdict = sata_pkg::VERDICT_IGNORED;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next        = state_reg;
        tok0_next         = tok0_reg;
        tok0_next.active  = 1'b0;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        out_verdict_next  = out_verdict_reg;
        out_removed_next  = out_removed_reg;
        out_live_next     = out_live_reg;
        pend_verdict_next = pend_verdict_reg;
        pend_removed_next = pend_removed_reg;
        pend_live_next    = pend_live_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    tok0_next.active     = 1'b1;
                    tok0_next.op         = in_op;
                    tok0_next.addr       = in_addr;
                    tok0_next.now        = in_now;
                    tok0_next.hit        = 1'b0;
                    tok0_next.free_found = 1'b0;
                    tok0_next.removed    = '0;
                    tok0_next.live       = '0;
                    state_next           = S_RUN;
                end
            end
            S_RUN: begin
                if (tok_end.active) begin
                    if (out_free) begin
                        m_tvalid_next    = 1'b1;
                        out_verdict_next = exit_verdict;
                        out_removed_next = sata_pkg::sat_count(tok_end.removed);
                        out_live_next    = sata_pkg::sat_count(exit_live);
                        state_next       = S_IDLE;
                    end else begin
                        pend_verdict_next = exit_verdict;
                        pend_removed_next = sata_pkg::sat_count(tok_end.removed);
                        pend_live_next    = sata_pkg::sat_count(exit_live);
                        state_next        = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    m_tvalid_next    = 1'b1;
                    out_verdict_next = pend_verdict_reg;
                    out_removed_next = pend_removed_reg;
                    out_live_next    = pend_live_reg;
                    state_next       = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        tok0_reg.op         <= tok0_next.op;
        tok0_reg.addr       <= tok0_next.addr;
        tok0_reg.now        <= tok0_next.now;
        tok0_reg.hit        <= tok0_next.hit;
        tok0_reg.free_found <= tok0_next.free_found;
        tok0_reg.removed    <= tok0_next.removed;
        tok0_reg.live       <= tok0_next.live;
        out_verdict_reg     <= out_verdict_next;
        out_removed_reg     <= out_removed_next;
        out_live_reg        <= out_live_next;
        pend_verdict_reg    <= pend_verdict_next;
        pend_removed_reg    <= pend_removed_next;
        pend_live_reg       <= pend_live_next;
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            tok0_reg.active <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            tok0_reg.active <= tok0_next.active;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_live_reg, out_removed_reg, out_verdict_reg};

endmodule

@@ src/sata_checker.sv @@
// ----------------------------------------------------------------------------
// sata_checker
// Port-level checks of the seen-address table, bound to the top level.
// ----------------------------------------------------------------------------
module sata_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [15:0]   m_tdata
);

    // a held result beat keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one item at a time: no second input beat right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // only sweeps remove entries
    a_removed_sweep_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != sata_pkg::VERDICT_SWEEP) |-> m_tdata[7:3] == 5'd0)
        else $error("removed count on a report result");

    // live count never exceeds the table
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[12:8] <= sata_pkg::LIVE_MAX)
        else $error("live count beyond table size");

endmodule

bind seen_address_table_with_aging_top sata_checker u_sata_checker (.*);
